// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/obb_pkg.sv -----
// ---------------------------------------------------------------------------
// OBB overlap package
// Widths, register indexes and codes for the box overlap test.
// ---------------------------------------------------------------------------
package obb_pkg;

    localparam int AXIS_FRAC_BITS = 14;
    localparam int COORD_BITS     = 16;

    localparam int WORD_BITS = 48;
    localparam int AB   = AXIS_FRAC_BITS + 2;
    localparam int CB   = COORD_BITS;
    localparam int LW   = 3 * AB + 3 * CB + WORD_BITS;
    localparam int PW   = 2 * AB;
    localparam int RW   = PW + 2;
    localparam int ARW  = RW + 1;
    localparam int DW   = CB + 1;
    localparam int DPW  = DW + AB;
    localparam int SW   = DPW + 2;
    localparam int EW   = CB + 1;
    localparam int EPW  = EW + ARW;
    localparam int SPW  = SW + RW;
    localparam int W    = SPW + 3 * AXIS_FRAC_BITS + EW;

    localparam int NUM_AXES = 15;

    typedef enum logic [2:0] {
        REG_OWN_AXIS_X = 3'd0,
        REG_OWN_AXIS_Y = 3'd1,
        REG_OWN_AXIS_Z = 3'd2,
        REG_OWN_CENTRE = 3'd3,
        REG_OWN_EXTENT = 3'd4
    } cfg_index_t;

    localparam logic [3:0] NO_AXIS = 4'd15;

endpackage

// ----- hw/rtl/obb_obb_overlap.sv -----
// ---------------------------------------------------------------------------
// OBB overlap test
// Separating axis test of a streamed box against a configured reference box.
// ---------------------------------------------------------------------------
// The block takes one box per cycle while the output is not stalled and returns
// one result per box; each box passes through five register stages (dot products,
// sums and magnitudes, extent and distance products, axis compares, first-axis
// encode), and the whole pipeline holds while a result waits.
`include "assert_macros.svh"

module obb_obb_overlap (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // other_axis_x, other_axis_y, other_axis_z, other_centre, other_extent
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // overlap, separating_axis, zero fill
    output logic [7:0]   m_tdata
);

    localparam int AB  = obb_pkg::AB;
    localparam int CB  = obb_pkg::CB;
    localparam int LW  = obb_pkg::LW;
    localparam int PW  = obb_pkg::PW;
    localparam int RW  = obb_pkg::RW;
    localparam int ARW = obb_pkg::ARW;
    localparam int DW  = obb_pkg::DW;
    localparam int DPW = obb_pkg::DPW;
    localparam int SW  = obb_pkg::SW;
    localparam int EPW = obb_pkg::EPW;
    localparam int SPW = obb_pkg::SPW;
    localparam int W   = obb_pkg::W;
    localparam int AF  = obb_pkg::AXIS_FRAC_BITS;
    localparam int NA  = obb_pkg::NUM_AXES;

    logic [47:0] cfg_reg [5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < 5; n++) cfg_reg[n] <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                obb_pkg::REG_OWN_AXIS_X: cfg_reg[0] <= cfg_wdata;
                obb_pkg::REG_OWN_AXIS_Y: cfg_reg[1] <= cfg_wdata;
                obb_pkg::REG_OWN_AXIS_Z: cfg_reg[2] <= cfg_wdata;
                obb_pkg::REG_OWN_CENTRE: cfg_reg[3] <= cfg_wdata;
                obb_pkg::REG_OWN_EXTENT: cfg_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    assign en       = !(m_valid_reg && !m_tready);
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
        end
    end

    // Field decode.
    logic signed [AB-1:0] ra [3][3];
    logic signed [AB-1:0] rb [3][3];
    logic signed [CB-1:0] ca [3];
    logic signed [CB-1:0] cb [3];
    logic        [CB-1:0] ea [3];
    logic        [CB-1:0] eb_in [3];
    logic        [LW-1:0] wa [5];
    logic        [LW-1:0] wb [5];

    always_comb begin
        for (int n = 0; n < 5; n++) begin
            wa[n] = LW'(cfg_reg[n]);
            wb[n] = LW'(s_tdata[n*48 +: 48]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ra[i][j] = signed'(wa[i][j*AB +: AB]);
                rb[i][j] = signed'(wb[i][j*AB +: AB]);
            end
            ca[i]    = signed'(wa[3][i*CB +: CB]);
            cb[i]    = signed'(wb[3][i*CB +: CB]);
            ea[i]    = wa[4][i*CB +: CB];
            eb_in[i] = wb[4][i*CB +: CB];
        end
    end

    // Stage 1: axis dot product terms and centre distance terms.
    logic signed [PW-1:0]  p_next  [3][3][3];
    logic signed [PW-1:0]  p_reg   [3][3][3];
    logic signed [DPW-1:0] dp_next [3][3];
    logic signed [DPW-1:0] dp_reg  [3][3];
    logic signed [DW-1:0]  d       [3];
    logic        [CB-1:0]  eb1_reg [3];

    always_comb begin
        for (int j = 0; j < 3; j++) d[j] = DW'(cb[j]) - DW'(ca[j]);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) p_next[i][k][j] = ra[i][j] * rb[k][j];
            end
            for (int j = 0; j < 3; j++) dp_next[i][j] = d[j] * ra[i][j];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= p_next;
            dp_reg  <= dp_next;
            eb1_reg <= eb_in;
        end
    end

    // Stage 2: rotation, its magnitude and the distance in A's frame.
    logic signed [RW-1:0]  r_next  [3][3];
    logic signed [RW-1:0]  r_reg   [3][3];
    logic signed [ARW-1:0] ar_next [3][3];
    logic signed [ARW-1:0] ar_reg  [3][3];
    logic signed [SW-1:0]  sa_next [3];
    logic signed [SW-1:0]  sa_reg  [3];
    logic        [CB-1:0]  eb2_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_next[i][k] = RW'(p_reg[i][k][0]) + RW'(p_reg[i][k][1])
                             + RW'(p_reg[i][k][2]);
                ar_next[i][k] = r_next[i][k][RW-1] ? -ARW'(r_next[i][k])
                                                   : ARW'(r_next[i][k]);
            end
            sa_next[i] = SW'(dp_reg[i][0]) + SW'(dp_reg[i][1]) + SW'(dp_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_next;
            ar_reg  <= ar_next;
            sa_reg  <= sa_next;
            eb2_reg <= eb1_reg;
        end
    end

    // Stage 3: extent and distance products.
    logic signed [EPW-1:0] xa_next [3][3][3];
    logic signed [EPW-1:0] xa_reg  [3][3][3];
    logic signed [EPW-1:0] xb_next [3][3][3];
    logic signed [EPW-1:0] xb_reg  [3][3][3];
    logic signed [SPW-1:0] sr_next [3][3][3];
    logic signed [SPW-1:0] sr_reg  [3][3][3];
    logic signed [SW-1:0]  sa3_reg [3];
    logic        [CB-1:0]  eb3_reg [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                for (int k = 0; k < 3; k++) begin
                    xa_next[a][b][k] = signed'({1'b0, ea[a]}) * ar_reg[b][k];
                    xb_next[a][b][k] = signed'({1'b0, eb2_reg[a]}) * ar_reg[b][k];
                    sr_next[a][b][k] = sa_reg[a] * r_reg[b][k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg  <= xa_next;
            xb_reg  <= xb_next;
            sr_reg  <= sr_next;
            sa3_reg <= sa_reg;
            eb3_reg <= eb2_reg;
        end
    end

    // Stage 4: the fifteen axis compares.
    logic [NA-1:0] sep_next, sep_reg;
    logic signed [W-1:0] lhs [NA];
    logic signed [W-1:0] rhs [NA];
    logic signed [W-1:0] acc, tmp;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc = W'(xb_reg[0][i][0]) + W'(xb_reg[1][i][1]) + W'(xb_reg[2][i][2]);
            tmp = W'(sa3_reg[i]);
            tmp = tmp[W-1] ? -tmp : tmp;
            lhs[i] = tmp <<< (2 * AF);
            rhs[i] = (W'(ea[i]) <<< (3 * AF)) + (acc <<< AF);
        end
        for (int k = 0; k < 3; k++) begin
            acc = W'(xa_reg[0][0][k]) + W'(xa_reg[1][1][k]) + W'(xa_reg[2][2][k]);
            tmp = W'(sr_reg[0][0][k]) + W'(sr_reg[1][1][k]) + W'(sr_reg[2][2][k]);
            lhs[3+k] = tmp[W-1] ? -tmp : tmp;
            rhs[3+k] = (acc <<< AF) + (W'(eb3_reg[k]) <<< (3 * AF));
        end
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                acc = W'(xa_reg[(i+1)%3][(i+2)%3][k]) + W'(xa_reg[(i+2)%3][(i+1)%3][k])
                    + W'(xb_reg[(k+1)%3][i][(k+2)%3]) + W'(xb_reg[(k+2)%3][i][(k+1)%3]);
                tmp = W'(sr_reg[(i+2)%3][(i+1)%3][k]) - W'(sr_reg[(i+1)%3][(i+2)%3][k]);
                lhs[6+3*i+k] = tmp[W-1] ? -tmp : tmp;
                rhs[6+3*i+k] = acc <<< AF;
            end
        end
        for (int n = 0; n < NA; n++) sep_next[n] = lhs[n] > rhs[n];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sep_reg <= sep_next;
        end
    end

    // Stage 5: first separating axis.
    logic [3:0] axis_next;
    logic [7:0] out_reg;

    always_comb begin
        axis_next = obb_pkg::NO_AXIS;
        for (int n = NA - 1; n >= 0; n--) begin
            if (sep_reg[n]) axis_next = 4'(n);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {3'b000, axis_next, axis_next == obb_pkg::NO_AXIS};
        end
    end

    assign m_tdata = out_reg;

    `ASSERT_IMPL(a_ovl_code, aclk, aresetn, m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == obb_pkg::NO_AXIS)), "overlap flag disagrees with axis code")
    `ASSERT_IMPL(a_ready_stall, aclk, aresetn, s_tready == !(m_tvalid && !m_tready), "ready does not follow the output stall")
    `ASSERT_IMPL(a_s4_adv, aclk, aresetn, (v4_reg && s_tready) |=> m_tvalid, "stage four request did not reach the output")

endmodule
